// ----- sv/sbf_pkg.sv -----
// ----------------------------------------------------------------------------
// sbf_pkg
// Shared types and constants for the stack blur frame engine.
// ----------------------------------------------------------------------------
package sbf_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int MAX_RADIUS_DEF = 31;

    localparam int PIX_W  = 32;
    localparam int SIZE_W = 9;
    localparam int RAD_W  = 5;
    localparam int CFG_W  = 9;
    localparam int COORD_W = 13;   // wide enough to compare a coordinate with any bound

    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_RUN   = 2'd1,
        MODE_READ  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_RADIUS = 2'd2,
        CFG_ALPHA  = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_TAP,
        ST_FLUSH,
        ST_DIV,
        ST_WRITE,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic item;      // single-cycle request (write, read, unused code)
        logic setup;     // latch run parameters, clear counters
        logic blur;      // memory addressing from blur counters
        logic tap;       // issue one tap read
        logic div;       // one quotient bit
        logic pix_wr;    // store result pixel, advance position
        logic resp_run;  // report end of run
    } t_cmd;

    typedef struct packed {
        logic rad_zero;
        logic tap_last;
        logic div_last;
        logic frame_last;
    } t_stat;

endpackage

// ----- sv/sbf_ctrl.sv -----
// ----------------------------------------------------------------------------
// sbf_ctrl
// Sequencer for requests and for the two blur passes.
// ----------------------------------------------------------------------------
module sbf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [1:0]       i_mode,
    input  sbf_pkg::t_stat   i_stat,
    output sbf_pkg::t_cmd    o_cmd,
    output logic             o_busy
);

    sbf_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            sbf_pkg::ST_IDLE: begin
                if (i_start && i_mode == sbf_pkg::MODE_RUN) n_state = sbf_pkg::ST_SETUP;
            end
            sbf_pkg::ST_SETUP: begin
                n_state = i_stat.rad_zero ? sbf_pkg::ST_FINISH : sbf_pkg::ST_TAP;
            end
            sbf_pkg::ST_TAP: begin
                if (i_stat.tap_last) n_state = sbf_pkg::ST_FLUSH;
            end
            sbf_pkg::ST_FLUSH: n_state = sbf_pkg::ST_DIV;
            sbf_pkg::ST_DIV: begin
                if (i_stat.div_last) n_state = sbf_pkg::ST_WRITE;
            end
            sbf_pkg::ST_WRITE: begin
                n_state = i_stat.frame_last ? sbf_pkg::ST_FINISH : sbf_pkg::ST_TAP;
            end
            sbf_pkg::ST_FINISH: n_state = sbf_pkg::ST_IDLE;
            default: n_state = sbf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            sbf_pkg::ST_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.item = i_start && (i_mode != sbf_pkg::MODE_RUN);
            end
            sbf_pkg::ST_SETUP: o_cmd.setup = 1'b1;
            sbf_pkg::ST_TAP: begin
                o_cmd.blur = 1'b1;
                o_cmd.tap  = 1'b1;
            end
            sbf_pkg::ST_FLUSH: o_cmd.blur = 1'b1;
            sbf_pkg::ST_DIV: begin
                o_cmd.blur = 1'b1;
                o_cmd.div  = 1'b1;
            end
            sbf_pkg::ST_WRITE: begin
                o_cmd.blur   = 1'b1;
                o_cmd.pix_wr = 1'b1;
            end
            sbf_pkg::ST_FINISH: o_cmd.resp_run = 1'b1;
            default: o_busy = 1'b1;
        endcase
    end

endmodule

// ----- sv/sbf_dp.sv -----
// ----------------------------------------------------------------------------
// sbf_dp
// Frame and row-pass memories, tap accumulators and per-channel divider.
// ----------------------------------------------------------------------------
module sbf_dp #(
    parameter int MAX_WIDTH  = sbf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sbf_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_RADIUS = sbf_pkg::MAX_RADIUS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_index,
    input  logic [sbf_pkg::CFG_W-1:0] i_cfg_data,
    input  logic [1:0]                i_mode,
    input  logic [7:0]                i_col,
    input  logic [7:0]                i_row,
    input  logic [sbf_pkg::PIX_W-1:0] i_pixel_in,
    input  sbf_pkg::t_cmd             i_cmd,
    output sbf_pkg::t_stat            o_stat,
    output logic                      o_valid,
    output logic [sbf_pkg::PIX_W-1:0] o_pixel_out,
    output logic                      o_run_done
);

    localparam int XW    = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int LW    = (XW > YW) ? XW : YW;
    localparam int AW    = XW + YW;
    localparam int DEPTH = 1 << AW;
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int IW    = RW + 1;
    localparam int WTW   = RW + 1;
    localparam int DW    = 2 * WTW;
    localparam int SW    = DW + 8;
    localparam int KW    = ((LW > RW) ? LW : RW) + 2;
    localparam int CXW   = sbf_pkg::COORD_W;

    // configuration
    logic [sbf_pkg::SIZE_W-1:0] r_cfg_w, r_cfg_h;
    logic [sbf_pkg::RAD_W-1:0]  r_cfg_r;
    logic                       r_cfg_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= sbf_pkg::SIZE_W'(256);
            r_cfg_h <= sbf_pkg::SIZE_W'(256);
            r_cfg_r <= '0;
            r_cfg_a <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sbf_pkg::CFG_WIDTH:  r_cfg_w <= i_cfg_data;
                sbf_pkg::CFG_HEIGHT: r_cfg_h <= i_cfg_data;
                sbf_pkg::CFG_RADIUS: r_cfg_r <= i_cfg_data[sbf_pkg::RAD_W-1:0];
                sbf_pkg::CFG_ALPHA:  r_cfg_a <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective run parameters
    logic [LW:0]     w_eff, h_eff;
    logic [RW-1:0]   r_eff;
    logic [DW-1:0]   rp1;

    always_comb begin
        if (r_cfg_w == '0)                       w_eff = (LW+1)'(1);
        else if (CXW'(r_cfg_w) > CXW'(MAX_WIDTH)) w_eff = (LW+1)'(MAX_WIDTH);
        else                                     w_eff = (LW+1)'(r_cfg_w);
        if (r_cfg_h == '0)                        h_eff = (LW+1)'(1);
        else if (CXW'(r_cfg_h) > CXW'(MAX_HEIGHT)) h_eff = (LW+1)'(MAX_HEIGHT);
        else                                      h_eff = (LW+1)'(r_cfg_h);
        if (CXW'(r_cfg_r) > CXW'(MAX_RADIUS)) r_eff = RW'(MAX_RADIUS);
        else                                  r_eff = RW'(r_cfg_r);
        rp1 = DW'(r_eff) + DW'(1);
    end

    logic [LW:0]            r_len_w, r_len_h;
    logic [RW-1:0]          r_rad;
    logic [DW-1:0]          r_div;
    logic                   r_pass;
    logic [LW-1:0]          r_line, r_pos;
    logic signed [IW-1:0]   r_tap;
    logic [2:0]             r_bit;

    logic [LW:0]            along, across;
    logic                   pos_last, line_last;

    assign along     = r_pass ? r_len_h : r_len_w;
    assign across    = r_pass ? r_len_w : r_len_h;
    assign pos_last  = ({1'b0, r_pos}  == along  - (LW+1)'(1));
    assign line_last = ({1'b0, r_line} == across - (LW+1)'(1));

    assign o_stat.rad_zero   = (r_cfg_r == '0);
    assign o_stat.tap_last   = (r_tap == $signed({1'b0, r_rad}));
    assign o_stat.div_last   = (r_bit == 3'd0);
    assign o_stat.frame_last = pos_last && line_last && r_pass;

    // tap position, clamped to the line
    logic signed [KW-1:0] k, lim;
    logic [LW-1:0]        kc;
    logic [IW-1:0]        tmag;
    logic [WTW-1:0]       wt;

    always_comb begin
        k   = $signed(KW'(r_pos)) + KW'(r_tap);
        lim = $signed(KW'(along) - KW'(1));
        if (k < 0)        kc = '0;
        else if (k > lim) kc = lim[LW-1:0];
        else              kc = k[LW-1:0];
        tmag = r_tap[IW-1] ? IW'(-r_tap) : IW'(r_tap);
        wt   = WTW'(r_rad) + WTW'(1) - WTW'(tmag);
    end

    logic [LW-1:0] tap_row, tap_col, wr_row, wr_col;
    logic [AW-1:0] tap_addr, wr_addr, item_addr;
    logic [CXW-1:0] ext_col, ext_row;
    logic           item_ok;

    assign tap_row   = r_pass ? kc : r_line;
    assign tap_col   = r_pass ? r_line : kc;
    assign wr_row    = r_pass ? r_pos : r_line;
    assign wr_col    = r_pass ? r_line : r_pos;
    assign tap_addr  = {tap_row[YW-1:0], tap_col[XW-1:0]};
    assign wr_addr   = {wr_row[YW-1:0], wr_col[XW-1:0]};
    assign ext_col   = CXW'(i_col);
    assign ext_row   = CXW'(i_row);
    assign item_ok   = (ext_col < CXW'(MAX_WIDTH)) && (ext_row < CXW'(MAX_HEIGHT));
    assign item_addr = {ext_row[YW-1:0], ext_col[XW-1:0]};

    // result pixel
    logic [7:0]               r_q [4];
    logic [sbf_pkg::PIX_W-1:0] res_pix;

    always_comb begin
        res_pix = {r_q[3], r_q[2], r_q[1], r_q[0]};
        if (r_pass && !r_cfg_a) res_pix[31:24] = sbf_pkg::ALPHA_OPAQUE;
    end

    // memories
    logic [sbf_pkg::PIX_W-1:0] m_frame [DEPTH];
    logic [sbf_pkg::PIX_W-1:0] m_rows  [DEPTH];
    logic [sbf_pkg::PIX_W-1:0] r_frame_q, r_row_q;
    logic                      fr_we, rw_we;
    logic [AW-1:0]             fr_waddr, fr_raddr;
    logic [sbf_pkg::PIX_W-1:0] fr_wdata;

    assign fr_we    = (i_cmd.item && i_mode == sbf_pkg::MODE_WRITE && item_ok)
                      || (i_cmd.pix_wr && r_pass);
    assign fr_waddr = i_cmd.pix_wr ? wr_addr : item_addr;
    assign fr_wdata = i_cmd.pix_wr ? res_pix : i_pixel_in;
    assign fr_raddr = i_cmd.blur ? tap_addr : item_addr;
    assign rw_we    = i_cmd.pix_wr && !r_pass;

    always_ff @(posedge i_clk) begin
        if (fr_we) m_frame[fr_waddr] <= fr_wdata;
        r_frame_q <= m_frame[fr_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (rw_we) m_rows[wr_addr] <= res_pix;
        r_row_q <= m_rows[tap_addr];
    end

    // run counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass <= 1'b0;
            r_line <= '0;
            r_pos  <= '0;
            r_tap  <= '0;
        end else if (i_cmd.setup) begin
            r_pass  <= 1'b0;
            r_line  <= '0;
            r_pos   <= '0;
            r_tap   <= -$signed({1'b0, r_eff});
            r_len_w <= w_eff;
            r_len_h <= h_eff;
            r_rad   <= r_eff;
            r_div   <= rp1 * rp1;
        end else if (i_cmd.tap) begin
            r_tap <= r_tap + IW'(1);
        end else if (i_cmd.pix_wr) begin
            r_tap <= -$signed({1'b0, r_rad});
            if (pos_last) begin
                r_pos <= '0;
                if (line_last) begin
                    r_line <= '0;
                    r_pass <= 1'b1;
                end else begin
                    r_line <= r_line + LW'(1);
                end
            end else begin
                r_pos <= r_pos + LW'(1);
            end
        end
    end

    // accumulate taps, then restoring division one quotient bit a cycle
    logic                      r_tap_v;
    logic [WTW-1:0]            r_wt_d;
    logic [SW-1:0]             r_acc [4];
    logic [sbf_pkg::PIX_W-1:0] tap_data;
    logic [SW-1:0]             dsh;
    logic [8+WTW-1:0]          prod [4];

    assign tap_data = r_pass ? r_row_q : r_frame_q;
    assign dsh      = SW'(r_div) << r_bit;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            prod[c] = tap_data[8*c +: 8] * r_wt_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_v <= 1'b0;
        end else begin
            r_tap_v <= i_cmd.tap;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wt_d <= wt;
        if (i_cmd.setup || i_cmd.pix_wr) begin
            r_bit <= 3'd7;
            for (int c = 0; c < 4; c++) r_acc[c] <= '0;
        end else if (r_tap_v) begin
            for (int c = 0; c < 4; c++) r_acc[c] <= r_acc[c] + SW'(prod[c]);
        end else if (i_cmd.div) begin
            r_bit <= r_bit - 3'd1;
            for (int c = 0; c < 4; c++) begin
                if (r_acc[c] >= dsh) begin
                    r_acc[c] <= r_acc[c] - dsh;
                    r_q[c]   <= {r_q[c][6:0], 1'b1};
                end else begin
                    r_q[c]   <= {r_q[c][6:0], 1'b0};
                end
            end
        end
    end

    // response
    logic r_valid, r_done, r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_done  <= 1'b0;
            r_rd_ok <= 1'b0;
        end else begin
            r_valid <= i_cmd.item || i_cmd.resp_run;
            r_done  <= i_cmd.resp_run;
            r_rd_ok <= i_cmd.item && (i_mode == sbf_pkg::MODE_READ) && item_ok;
        end
    end

    assign o_valid     = r_valid;
    assign o_run_done  = r_done;
    assign o_pixel_out = r_rd_ok ? r_frame_q : '0;

endmodule

// ----- sv/stack_blur_frame.sv -----
// ----------------------------------------------------------------------------
// stack_blur_frame
// Frame store with an in-place two-pass stack blur.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge with i_start high and o_busy low.
//   i_mode selects write pixel, read pixel or run blur; i_col/i_row address
//   the pixel, i_pixel_in carries ARGB data for a write.
//   Each request gives exactly one result, shown for one cycle with o_valid:
//   o_pixel_out holds the read pixel (zero otherwise), o_run_done marks a run.
//   Write and read requests answer in the next cycle and may follow each
//   other every cycle; the read data comes from the registered memory.
//   A run holds o_busy through its setup and finish states only with zero
//   radius; otherwise, in both passes, every output pixel steps through 2r+1 tap
//   reads on the single read port, one flush, 8 divide steps and a write.
//   Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) land at once;
//   issue them only while no request is in flight.
//   Reset clears the sequencer and loads width 256, height 256, radius 0,
//   alpha blur on; pixel memories are not cleared. The receiver cannot
//   stall, so o_valid is never held.
// ----------------------------------------------------------------------------
module stack_blur_frame #(
    parameter int MAX_WIDTH  = sbf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sbf_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_RADIUS = sbf_pkg::MAX_RADIUS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_index,
    input  logic [sbf_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      i_start,
    output logic                      o_busy,
    input  logic [1:0]                i_mode,
    input  logic [7:0]                i_col,
    input  logic [7:0]                i_row,
    input  logic [sbf_pkg::PIX_W-1:0] i_pixel_in,
    output logic                      o_valid,
    output logic [sbf_pkg::PIX_W-1:0] o_pixel_out,
    output logic                      o_run_done
);

    sbf_pkg::t_cmd  cmd;
    sbf_pkg::t_stat stat;

    // sequencer: decides what the datapath does each cycle
    sbf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_mode  (i_mode),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    // memories, counters, accumulate and divide
    sbf_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_mode      (i_mode),
        .i_col       (i_col),
        .i_row       (i_row),
        .i_pixel_in  (i_pixel_in),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_valid     (o_valid),
        .o_pixel_out (o_pixel_out),
        .o_run_done  (o_run_done)
    );

endmodule

// ----- sv/sbf_checker.sv -----
// ----------------------------------------------------------------------------
// sbf_port_checks
// Port-level checks for the stack blur frame engine.
// ----------------------------------------------------------------------------
module sbf_port_checks (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic [1:0]  i_mode,
    input logic        o_valid,
    input logic [31:0] o_pixel_out,
    input logic        o_run_done
);

    // a short request answers in the very next cycle, never as a run
    a_short_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_mode != sbf_pkg::MODE_RUN) |=> (o_valid && !o_run_done))
        else $error("short request not answered next cycle");

    // a run request keeps the block busy
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_mode == sbf_pkg::MODE_RUN) |=> (o_busy && !o_valid))
        else $error("run request did not occupy the block");

    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_run_done |-> (o_valid && o_pixel_out == '0))
        else $error("run completion without strobe or with pixel data");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> (o_pixel_out == '0 && !o_run_done))
        else $error("result ports active without strobe");

endmodule

bind stack_blur_frame sbf_port_checks u_sbf_port_checks (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .i_mode      (i_mode),
    .o_valid     (o_valid),
    .o_pixel_out (o_pixel_out),
    .o_run_done  (o_run_done)
);

// ----- sim/sbf_checker.sv -----
// ----------------------------------------------------------------------------
// sbf_checker
// Watches the request, configuration and result ports of the stack blur frame
// engine. It keeps its own copy of the frame, the row pass store and the
// settings, works out the result of every accepted request and compares the
// results in order.
// ----------------------------------------------------------------------------
module sbf_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_index,
    input  logic [sbf_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      i_start,
    input  logic                      i_busy,
    input  logic [1:0]                i_mode,
    input  logic [7:0]                i_col,
    input  logic [7:0]                i_row,
    input  logic [sbf_pkg::PIX_W-1:0] i_pixel_in,
    input  logic                      i_valid,
    input  logic [sbf_pkg::PIX_W-1:0] i_pixel_out,
    input  logic                      i_run_done,
    output int                        o_fail_count,
    output int                        o_pending
);

    localparam int LINE = sbf_pkg::MAX_WIDTH_DEF;
    localparam int NPIX = sbf_pkg::MAX_WIDTH_DEF * sbf_pkg::MAX_HEIGHT_DEF;

    typedef struct {
        logic [31:0] pixel;
        logic        done;
    } t_answer;

    logic [31:0] frame_px [0:NPIX-1];
    logic [31:0] pass_px  [0:NPIX-1];
    logic [8:0]  width_q, height_q;
    logic [4:0]  radius_q;
    logic        alpha_q;
    t_answer     answers [$];
    int          fails;

    function automatic int fit_size(logic [8:0] v, int maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    // Weighted sum over one line: a row of the frame, or a column of the pass store
    function automatic logic [31:0] blur_point(bit vert, int line_no, int len, int pos, int r);
        int          sum [4];
        int          k, w, div;
        logic [31:0] p, res;
        for (int c = 0; c < 4; c++) sum[c] = 0;
        div = (r + 1) * (r + 1);
        for (int i = -r; i <= r; i++) begin
            k = pos + i;
            if (k < 0) k = 0;
            if (k > len - 1) k = len - 1;
            w = r + 1 - (i < 0 ? -i : i);
            p = vert ? pass_px[k*LINE + line_no] : frame_px[line_no*LINE + k];
            for (int c = 0; c < 4; c++) sum[c] += p[8*c +: 8] * w;
        end
        for (int c = 0; c < 4; c++) res[8*c +: 8] = 8'(sum[c] / div);
        return res;
    endfunction

    task automatic blur_frame();
        int          w, h, r;
        logic [31:0] p;
        w = fit_size(width_q, sbf_pkg::MAX_WIDTH_DEF);
        h = fit_size(height_q, sbf_pkg::MAX_HEIGHT_DEF);
        r = (radius_q > sbf_pkg::MAX_RADIUS_DEF) ? sbf_pkg::MAX_RADIUS_DEF : int'(radius_q);
        if (r < 1) return;
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
                pass_px[y*LINE + x] = blur_point(1'b0, y, w, x, r);
        for (int x = 0; x < w; x++)
            for (int y = 0; y < h; y++) begin
                p = blur_point(1'b1, x, h, y, r);
                if (!alpha_q) p[31:24] = sbf_pkg::ALPHA_OPAQUE;
                frame_px[y*LINE + x] = p;
            end
    endtask

    always @(posedge i_clk) begin
        t_answer a;
        if (!i_rst_n) begin
            width_q  = 9'd256;
            height_q = 9'd256;
            radius_q = 5'd0;
            alpha_q  = 1'b1;
            answers.delete();
            fails = 0;
        end else begin
            if (i_cfg_we) begin
                case (sbf_pkg::t_cfg_idx'(i_cfg_index))
                    sbf_pkg::CFG_WIDTH:  width_q  = i_cfg_data[8:0];
                    sbf_pkg::CFG_HEIGHT: height_q = i_cfg_data[8:0];
                    sbf_pkg::CFG_RADIUS: radius_q = i_cfg_data[4:0];
                    sbf_pkg::CFG_ALPHA:  alpha_q  = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_valid) begin
                if (answers.size() == 0) begin
                    $error("result with nothing outstanding: pixel_out %h run_done %b",
                           i_pixel_out, i_run_done);
                    fails++;
                end else begin
                    a = answers.pop_front();
                    if (i_pixel_out !== a.pixel) begin
                        $error("pixel_out: expected %h, got %h", a.pixel, i_pixel_out);
                        fails++;
                    end
                    if (i_run_done !== a.done) begin
                        $error("run_done: expected %b, got %b", a.done, i_run_done);
                        fails++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                a.pixel = '0;
                a.done  = 1'b0;
                case (i_mode)
                    sbf_pkg::MODE_WRITE: frame_px[i_row*LINE + i_col] = i_pixel_in;
                    sbf_pkg::MODE_RUN: begin
                        blur_frame();
                        a.done = 1'b1;
                    end
                    sbf_pkg::MODE_READ: a.pixel = frame_px[i_row*LINE + i_col];
                    default: ;
                endcase
                answers.push_back(a);
            end
        end
        o_fail_count <= fails;
        o_pending    <= answers.size();
    end
endmodule

// ----- sim/tb_stack_blur_frame.sv -----
// ----------------------------------------------------------------------------
// tb_stack_blur_frame
// Drives write, read, run and unused requests into the stack blur frame
// engine across a series of frame sizes, radii and alpha settings, and gives
// the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_stack_blur_frame;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         SETTLE      = 8;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_cfg_we = 1'b0;
    logic [1:0]                  i_cfg_index = '0;
    logic [sbf_pkg::CFG_W-1:0]   i_cfg_data = '0;
    logic                        i_start = 1'b0;
    logic [1:0]                  i_mode = '0;
    logic [7:0]                  i_col = '0;
    logic [7:0]                  i_row = '0;
    logic [sbf_pkg::PIX_W-1:0]   i_pixel_in = '0;
    logic                        o_busy, o_valid, o_run_done;
    logic [sbf_pkg::PIX_W-1:0]   o_pixel_out;
    int                          fail_count, pending;

    // Addresses known to hold a written pixel; reads only ever target these
    bit                   stored [0:65535];
    int                   stored_list [$];
    int                   sent;
    int                   used_w, used_h;

    stack_blur_frame DUT (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_start, .o_busy, .i_mode, .i_col, .i_row, .i_pixel_in,
        .o_valid, .o_pixel_out, .o_run_done
    );

    sbf_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_start, .i_busy(o_busy), .i_mode, .i_col, .i_row, .i_pixel_in,
        .i_valid(o_valid), .i_pixel_out(o_pixel_out), .i_run_done(o_run_done),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #(12 * 4000000);
        $display("FAILURE");
        $finish;
    end

    // Issue one request and hold it until the block takes it. Idle now and
    // then, except in the quiet stretch in the middle of the run. Busy is
    // looked at mid-cycle, where it shows what the next edge will see.
    task automatic send_request(logic [1:0] mode, logic [7:0] col, logic [7:0] row,
                                logic [31:0] pix);
        int addr;
        if (!(sent > 400 && sent < 650) && $urandom_range(99) < 7) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_start    <= 1'b1;
        i_mode     <= mode;
        i_col      <= col;
        i_row      <= row;
        i_pixel_in <= pix;
        @(negedge i_clk);
        while (o_busy) @(negedge i_clk);
        @(posedge i_clk);
        sent++;
        if (mode == sbf_pkg::MODE_WRITE) begin
            addr = row * 256 + col;
            if (!stored[addr]) begin
                stored[addr] = 1'b1;
                stored_list.push_back(addr);
            end
        end
    endtask

    // Write one register once everything outstanding has drained
    task automatic write_reg(sbf_pkg::t_cfg_idx idx, logic [sbf_pkg::CFG_W-1:0] val);
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic set_frame(logic [8:0] w, logic [8:0] h, logic [4:0] r, logic a);
        write_reg(sbf_pkg::CFG_WIDTH, w);
        write_reg(sbf_pkg::CFG_HEIGHT, h);
        write_reg(sbf_pkg::CFG_RADIUS, sbf_pkg::CFG_W'(r));
        write_reg(sbf_pkg::CFG_ALPHA, sbf_pkg::CFG_W'(a));
        used_w = (w == 0) ? 1 : (w > 256 ? 256 : int'(w));
        used_h = (h == 0) ? 1 : (h > 256 ? 256 : int'(h));
    endtask

    // Fill the used area so that a run never reads an unwritten pixel, then
    // mix writes, reads, runs and the unused code.
    task automatic frame_phase(int n);
        int          addr;
        int unsigned pick;
        for (int y = 0; y < used_h; y++)
            for (int x = 0; x < used_w; x++)
                send_request(sbf_pkg::MODE_WRITE, 8'(x), 8'(y), $urandom());
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                if ($urandom_range(1))
                    send_request(sbf_pkg::MODE_WRITE, 8'($urandom_range(used_w - 1)),
                                 8'($urandom_range(used_h - 1)), $urandom());
                else
                    send_request(sbf_pkg::MODE_WRITE, 8'($urandom()), 8'($urandom()),
                                 $urandom());
            end else if (pick < 90) begin
                if ($urandom_range(1))
                    addr = $urandom_range(used_h - 1) * 256 + $urandom_range(used_w - 1);
                else
                    addr = stored_list[$urandom_range(stored_list.size() - 1)];
                send_request(sbf_pkg::MODE_READ, 8'(addr % 256), 8'(addr / 256), $urandom());
            end else if (pick < 94) begin
                send_request(sbf_pkg::MODE_RUN, 8'($urandom()), 8'($urandom()), $urandom());
            end else begin
                send_request(MODE_UNUSED, 8'($urandom()), 8'($urandom()), $urandom());
            end
        end
    endtask

    initial begin
        sent = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: corner addresses and pixel extremes at reset settings,
        // a zero-radius run, the unused code and a read-back of all of it.
        send_request(sbf_pkg::MODE_WRITE, 8'd0, 8'd0, 32'h0000_0000);
        send_request(sbf_pkg::MODE_WRITE, 8'd255, 8'd255, 32'hffff_ffff);
        send_request(sbf_pkg::MODE_WRITE, 8'd255, 8'd0, 32'ha5a5_5a5a);
        send_request(sbf_pkg::MODE_WRITE, 8'd0, 8'd255, 32'h5a5a_a5a5);
        send_request(sbf_pkg::MODE_READ, 8'd0, 8'd0, 32'hffff_ffff);
        send_request(sbf_pkg::MODE_READ, 8'd255, 8'd255, 32'h0);
        send_request(MODE_UNUSED, 8'd255, 8'd255, 32'hffff_ffff);
        send_request(sbf_pkg::MODE_RUN, 8'd0, 8'd0, 32'h0);
        send_request(sbf_pkg::MODE_READ, 8'd255, 8'd0, 32'h0);
        send_request(sbf_pkg::MODE_READ, 8'd0, 8'd255, 32'h0);

        // Extreme settings: sizes of zero and above the bound, largest
        // radius on a one-pixel frame and on a full-length single row or column.
        set_frame(9'd1, 9'd1, 5'd31, 1'b1);
        frame_phase(12);
        set_frame(9'd0, 9'd0, 5'd5, 1'b0);
        frame_phase(12);
        set_frame(9'd511, 9'd1, 5'd31, 1'b1);
        frame_phase(20);
        set_frame(9'd1, 9'd300, 5'd31, 1'b0);
        frame_phase(20);
        set_frame(9'd2, 9'd9, 5'd0, 1'b0);
        frame_phase(12);

        // Random settings on small frames until the request count is reached
        while (sent < 1050)
            begin
            set_frame(9'($urandom_range(1, 8)), 9'($urandom_range(1, 8)),
                      5'($urandom_range(0, 31)), 1'($urandom_range(1)));
            frame_phase($urandom_range(40, 90));
        end

        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
